/* rtl/rgb_histogram_with_mode_defines.svh */
// Assertion macros used by the top-level histogram module.
`ifndef RGB_HISTOGRAM_WITH_MODE_DEFINES_SVH
`define RGB_HISTOGRAM_WITH_MODE_DEFINES_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define RHIST_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhist check failed");
// Antecedent implies consequent in the next cycle.
`define RHIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhist check failed");
`else
`define RHIST_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RHIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/rhist_pkg.sv */
`default_nettype none
package rhist_pkg;

    localparam int CHAN_W      = 16;
    localparam int FRAC_SHIFT  = 15;
    localparam int BIN_IDX_W   = 8;
    localparam int OUT_COUNT_W = 24;
    localparam int OUT_BIN_W   = 8;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [CHAN_W-1:0]     red;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     blue;
        logic [BIN_IDX_W-1:0]  bin_index;
    } t_in;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] count_red;
        logic [OUT_COUNT_W-1:0] count_green;
        logic [OUT_COUNT_W-1:0] count_blue;
        logic [OUT_BIN_W-1:0]   mode_red;
        logic [OUT_BIN_W-1:0]   mode_green;
        logic [OUT_BIN_W-1:0]   mode_blue;
    } t_out;

    typedef struct packed {
        logic sweeping;
        logic start_sweep;
    } t_back_stat;

endpackage
`default_nettype wire

/* rtl/rhist_fifo.sv */
`default_nettype none
module rhist_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/rhist_front.sv */
`default_nettype none
module rhist_front
    import rhist_pkg::*;
#(
    parameter int BIN_COUNT = 256,
    parameter int BW        = 8,
    parameter int EW        = 3 + 3 * 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire t_in           i_in,
    input  wire logic          i_sweeping,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output logic [EW-1:0]      o_q_data
);

    localparam int PW = CHAN_W + BW;

    logic          r_valid;
    logic [EW-1:0] r_entry;
    logic [EW-1:0] n_entry;
    logic          accept;
    logic          oor;

    // bin = floor(v * (BIN_COUNT-1) / 2^15), clamped to the last bin
    function automatic logic [BW-1:0] f_bin(input logic [CHAN_W-1:0] v);
        logic [PW-1:0] prod;
        logic [BW:0]   q;
        prod = PW'(v) * PW'(BIN_COUNT - 1);
        q    = prod[PW-1:FRAC_SHIFT];
        if (q > (BW + 1)'(BIN_COUNT - 1)) begin
            return BW'(BIN_COUNT - 1);
        end
        return q[BW-1:0];
    endfunction

    assign o_ready  = !i_sweeping && (!r_valid || !i_q_full);
    assign accept   = i_valid && o_ready;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = r_entry;
    assign oor      = (32'(i_in.bin_index) >= 32'(BIN_COUNT));

    always_comb begin
        unique case (i_in.kind)
            KIND_ADD: begin
                n_entry = {i_in.kind, 1'b0, f_bin(i_in.red), f_bin(i_in.green),
                           f_bin(i_in.blue)};
            end
            KIND_READ: begin
                n_entry = {i_in.kind, oor, BW'(i_in.bin_index), BW'(i_in.bin_index),
                           BW'(i_in.bin_index)};
            end
            default: begin
                n_entry = {i_in.kind, 1'b0, {(3 * BW){1'b0}}};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

/* rtl/rhist_back.sv */
`default_nettype none
module rhist_back
    import rhist_pkg::*;
#(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 24,
    parameter int BW          = 8,
    parameter int EW          = 3 + 3 * 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [EW-1:0] i_q_data,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    input  wire logic          i_out_full,
    output logic               o_out_push,
    output t_out               o_out_data,
    output t_back_stat         o_stat
);

    localparam int CW = COUNT_WIDTH;

    t_kind          head_kind;
    logic           head_oor;
    logic [BW-1:0]  head_addr [3];

    logic           a_go;
    logic           b_free;
    logic           b_push;
    logic           start_sweep;

    logic           r_b_valid;
    t_kind          r_b_kind;
    logic           r_b_oor;
    logic [BW-1:0]  r_b_addr [3];

    logic           r_sweep;
    logic [BW-1:0]  r_sweep_cnt;

    logic           wr_en;
    logic [BW-1:0]  wr_addr [3];
    logic [CW-1:0]  wr_data [3];

    logic           r_fw_valid;
    logic [BW-1:0]  r_fw_addr [3];
    logic [CW-1:0]  r_fw_data [3];

    logic [CW-1:0]  inc [3];
    logic [CW-1:0]  rd_count [3];
    logic [BW-1:0]  mode_out [3];

    assign head_kind = t_kind'(i_q_data[3*BW+2:3*BW+1]);
    assign head_oor  = i_q_data[3*BW];

    assign b_push      = r_b_valid && !i_out_full;
    assign b_free      = !r_b_valid || b_push;
    assign a_go        = !i_q_empty && !r_sweep && b_free;
    assign start_sweep = a_go && (head_kind == KIND_CLEAR);
    assign o_q_pop     = a_go;
    assign o_out_push  = b_push;
    assign wr_en       = r_sweep || (b_push && (r_b_kind == KIND_ADD));

    assign o_stat.sweeping    = r_sweep;
    assign o_stat.start_sweep = start_sweep;

    // Sweep zeros through all bins after reset and after a clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= 1'b1;
            r_sweep_cnt <= '0;
        end else if (start_sweep) begin
            r_sweep     <= 1'b1;
            r_sweep_cnt <= '0;
        end else if (r_sweep) begin
            r_sweep_cnt <= r_sweep_cnt + 1'b1;
            if (r_sweep_cnt == BW'(BIN_COUNT - 1)) begin
                r_sweep <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_go) begin
            r_b_valid <= 1'b1;
        end else if (b_push) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_kind <= head_kind;
            r_b_oor  <= head_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (wr_en) begin
            r_fw_valid <= 1'b1;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [CW-1:0] r_mem [BIN_COUNT];
        logic [CW-1:0] r_rd;
        logic [CW-1:0] cur;
        logic [BW-1:0] r_mode_bin, n_mode_bin;
        logic [CW-1:0] r_mode_cnt, n_mode_cnt;

        assign head_addr[c] = i_q_data[(2-c)*BW +: BW];
        assign wr_addr[c]   = r_sweep ? r_sweep_cnt : r_b_addr[c];
        assign wr_data[c]   = r_sweep ? '0 : inc[c];

        always_ff @(posedge i_clk) begin
            if (a_go) begin
                r_rd        <= r_mem[head_addr[c]];
                r_b_addr[c] <= head_addr[c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_addr[c]] <= wr_data[c];
                r_fw_addr[c]      <= wr_addr[c];
                r_fw_data[c]      <= wr_data[c];
            end
        end

        // Take the last write when the read raced it.
        assign cur    = (r_fw_valid && (r_fw_addr[c] == r_b_addr[c])) ? r_fw_data[c] : r_rd;
        assign inc[c] = (cur == {CW{1'b1}}) ? cur : cur + 1'b1;
        assign rd_count[c] = ((r_b_kind == KIND_READ) && !r_b_oor) ? cur : '0;

        always_comb begin
            n_mode_bin = r_mode_bin;
            n_mode_cnt = r_mode_cnt;
            case (r_b_kind)
                KIND_CLEAR: begin
                    n_mode_bin = '0;
                    n_mode_cnt = '0;
                end
                KIND_ADD: begin
                    if (r_b_addr[c] == r_mode_bin) begin
                        n_mode_cnt = inc[c];
                    end else if (inc[c] > r_mode_cnt) begin
                        n_mode_bin = r_b_addr[c];
                        n_mode_cnt = inc[c];
                    end
                end
                default: begin
                end
            endcase
        end

        assign mode_out[c] = n_mode_bin;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mode_bin <= '0;
                r_mode_cnt <= '0;
            end else if (b_push) begin
                r_mode_bin <= n_mode_bin;
                r_mode_cnt <= n_mode_cnt;
            end
        end
    end

    always_comb begin
        o_out_data.count_red   = OUT_COUNT_W'(rd_count[0]);
        o_out_data.count_green = OUT_COUNT_W'(rd_count[1]);
        o_out_data.count_blue  = OUT_COUNT_W'(rd_count[2]);
        o_out_data.mode_red    = OUT_BIN_W'(mode_out[0]);
        o_out_data.mode_green  = OUT_BIN_W'(mode_out[1]);
        o_out_data.mode_blue   = OUT_BIN_W'(mode_out[2]);
    end

endmodule
`default_nettype wire

/* rtl/rgb_histogram_with_mode.sv */
`default_nettype none
`include "rgb_histogram_with_mode_defines.svh"
// RGB histogram with running mode. Each word in is a clear, a pixel add or a bin
// read; each produces exactly one word out carrying the read bin's three counts
// (zero but for an in-range read) and the current red, green and blue mode bins.
// Sustained rate is one word per cycle unless a sweep runs or the output stalls:
// a front stage registers the bin index (one multiply per channel), a four-entry
// queue decouples it from the back end, which registers its reads of the three
// bin memories and writes the updated counts when the word moves on, forwarding
// the last write so repeated bins need no bubble. After reset and after every
// clear word the back end sweeps zeros through the bins, one bin per cycle, and
// input ready stays low during that sweep.
module rgb_histogram_with_mode
    import rhist_pkg::*;
#(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_in,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_out
);

    localparam int BW = $clog2(BIN_COUNT);
    localparam int EW = 3 + 3 * BW;
    localparam int OW = $bits(t_out);

    logic          q_push, q_full, q_pop, q_empty;
    logic [EW-1:0] q_wdata, q_rdata;
    logic          out_push, out_full, out_empty;
    t_out          out_wdata;
    logic [OW-1:0] out_rdata;
    t_back_stat    stat;

    rhist_front #(
        .BIN_COUNT (BIN_COUNT),
        .BW        (BW),
        .EW        (EW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_sweeping (stat.sweeping),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    rhist_fifo #(
        .WIDTH (EW),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    rhist_back #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH),
        .BW          (BW),
        .EW          (EW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_rdata),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_data (out_wdata),
        .o_stat     (stat)
    );

    rhist_fifo #(
        .WIDTH (OW),
        .DEPTH (2)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wdata),
        .o_full  (out_full),
        .i_pop   (i_ready),
        .o_data  (out_rdata),
        .o_empty (out_empty)
    );

    assign o_valid = !out_empty;
    assign o_out   = t_out'(out_rdata);

    // Input is held off for the whole bin sweep.
    `RHIST_ASSERT_SAME(a_sweep_blocks_input, i_clk, i_rst_n, stat.sweeping, !o_ready)
    // Apart from the one at reset, a sweep begins only after the back end took a clear word.
    `RHIST_ASSERT_SAME(a_sweep_needs_clear, i_clk, i_rst_n, $rose(stat.sweeping), $past(stat.start_sweep))
    `RHIST_ASSERT_NEXT(a_clear_starts_sweep, i_clk, i_rst_n, stat.start_sweep, stat.sweeping)

endmodule
`default_nettype wire
